@@ src/vhd_pkg.sv @@
// Shared types, constants and the arctangent table for the vector heading core.
// Used by every module of the block; depends on nothing.
`default_nettype none
package vhd_pkg;

  localparam int DEF_COORD_WIDTH  = 16;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int TABLE_LEN        = 32;
  localparam int GUARD_SHIFT      = 16;
  // Angle accumulator in degrees * 2^16; about +/-190 degrees fits easily.
  localparam int ZW               = 26;
  localparam int HEADING_W        = 16;
  localparam int OUT_SHIFT        = 9;
  localparam int FULL_TURN        = 46080;
  localparam int QUARTER_TURN     = 90 * (2 ** GUARD_SHIFT);
  localparam int ROUND_HALF       = 2 ** (OUT_SHIFT - 1);

  typedef struct packed {
    logic valid;
    logic zero;
  } vhd_ctl_t;

  // atan(2^-i) in degrees * 2^16, rounded
  function automatic int atan_deg(input int i);
    int val;
    case (i)
      0:  val = 2949120;
      1:  val = 1740967;
      2:  val = 919879;
      3:  val = 466945;
      4:  val = 234379;
      5:  val = 117304;
      6:  val = 58666;
      7:  val = 29335;
      8:  val = 14668;
      9:  val = 7334;
      10: val = 3667;
      11: val = 1833;
      12: val = 917;
      13: val = 458;
      14: val = 229;
      15: val = 115;
      16: val = 57;
      17: val = 29;
      18: val = 14;
      19: val = 7;
      20: val = 4;
      21: val = 2;
      22: val = 1;
      default: val = 0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

@@ src/vhd_prerot.sv @@
// Entry stage: scales the coordinates, folds the left half plane onto the right.
// Depends on vhd_pkg.
`default_nettype none
module vhd_prerot #(
  parameter int COORD_WIDTH = vhd_pkg::DEF_COORD_WIDTH,
  parameter int XW          = vhd_pkg::DEF_COORD_WIDTH + vhd_pkg::GUARD_SHIFT + 3
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                en,
  input  wire                                valid_in,
  input  wire  signed [COORD_WIDTH-1:0]      x_coord,
  input  wire  signed [COORD_WIDTH-1:0]      y_coord,
  output vhd_pkg::vhd_ctl_t                  ctl_out,
  output logic signed [XW-1:0]               x_out,
  output logic signed [XW-1:0]               y_out,
  output logic signed [vhd_pkg::ZW-1:0]      z_out
);
  import vhd_pkg::*;

  localparam logic signed [ZW-1:0] QUARTER = ZW'(QUARTER_TURN);

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  assign x_ext = XW'(x_coord) <<< GUARD_SHIFT;
  assign y_ext = XW'(y_coord) <<< GUARD_SHIFT;

  always_comb begin
    x_next = x_ext;
    y_next = y_ext;
    z_next = '0;
    if (x_coord < 0) begin
      if (y_coord >= 0) begin
        x_next = y_ext;
        y_next = -x_ext;
        z_next = QUARTER;
      end else begin
        x_next = -y_ext;
        y_next = x_ext;
        z_next = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= valid_in;
    end
    if (en) begin
      ctl_out.zero <= (x_coord == '0) && (y_coord == '0);
      x_out        <= x_next;
      y_out        <= y_next;
      z_out        <= z_next;
    end
  end

endmodule
`default_nettype wire

@@ src/vhd_cell.sv @@
// One CORDIC vectoring cell: a single micro-rotation toward the x axis.
// Depends on vhd_pkg for the angle table and control struct.
`default_nettype none
module vhd_cell #(
  parameter int XW  = vhd_pkg::DEF_COORD_WIDTH + vhd_pkg::GUARD_SHIFT + 3,
  parameter int IDX = 0
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                en,
  input  vhd_pkg::vhd_ctl_t                  ctl_in,
  input  wire  signed [XW-1:0]               x_in,
  input  wire  signed [XW-1:0]               y_in,
  input  wire  signed [vhd_pkg::ZW-1:0]      z_in,
  output vhd_pkg::vhd_ctl_t                  ctl_out,
  output logic signed [XW-1:0]               x_out,
  output logic signed [XW-1:0]               y_out,
  output logic signed [vhd_pkg::ZW-1:0]      z_out
);
  import vhd_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = ZW'(atan_deg(IDX));

  logic signed [XW-1:0] x_sh;
  logic signed [XW-1:0] y_sh;
  logic                 rot_down;

  assign x_sh     = x_in >>> IDX;
  assign y_sh     = y_in >>> IDX;
  assign rot_down = y_in > 0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.zero <= ctl_in.zero;
      if (rot_down) begin
        x_out <= x_in + y_sh;
        y_out <= y_in - x_sh;
        z_out <= z_in + ANGLE;
      end else begin
        x_out <= x_in - y_sh;
        y_out <= y_in + x_sh;
        z_out <= z_in - ANGLE;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/vhd_post.sv @@
// Output stage: adds the 90 degree offset, rounds to 1/128 degree, wraps to [0, 360).
// Depends on vhd_pkg.
`default_nettype none
module vhd_post (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                en,
  input  vhd_pkg::vhd_ctl_t                  ctl_in,
  input  wire  signed [vhd_pkg::ZW-1:0]      z_in,
  output logic                               valid_out,
  output logic [vhd_pkg::HEADING_W-1:0]      heading
);
  import vhd_pkg::*;

  localparam int QW = ZW - OUT_SHIFT;
  localparam logic signed [ZW-1:0] OFFSET = ZW'(QUARTER_TURN + ROUND_HALF);
  localparam logic signed [QW-1:0] TURN   = QW'(FULL_TURN);

  logic signed [ZW-1:0] r_sum;
  logic signed [QW-1:0] q_val;
  logic signed [QW-1:0] q_wrap;

  // a zero vector has no direction: take its angle as zero
  assign r_sum  = (ctl_in.zero ? '0 : z_in) + OFFSET;
  assign q_val  = r_sum[ZW-1:OUT_SHIFT];
  assign q_wrap = (q_val < 0) ? q_val + TURN : q_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading <= q_wrap[HEADING_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ src/vector_heading_degrees_core.sv @@
// Vector heading core: entry stage, a chain of CORDIC_STEPS (at most TABLE_LEN) vectoring cells, output stage.
// Registered stages in order: fold stage, one cell per step, round/wrap stage.
// Throughput one transaction per cycle; the whole chain advances together and holds
// while a result waits on m_tready, so s_tready follows the output register.
// Synchronous reset clears the valid bit of every stage; no other state.
// Depends on vhd_pkg, vhd_prerot, vhd_cell, vhd_post.
`default_nettype none
module vector_heading_degrees_core #(
  parameter int COORD_WIDTH  = vhd_pkg::DEF_COORD_WIDTH,
  parameter int CORDIC_STEPS = vhd_pkg::DEF_CORDIC_STEPS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // s_tdata, low bit up: x_coord, y_coord, zero fill
  input  wire  [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // m_tdata, low bit up: heading
  output logic [vhd_pkg::HEADING_W-1:0]        m_tdata
);
  import vhd_pkg::*;

  localparam int XW     = COORD_WIDTH + GUARD_SHIFT + 3;
  localparam int NCELLS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  logic                        adv;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  vhd_ctl_t             ctl_s [0:NCELLS];
  logic signed [XW-1:0] x_s   [0:NCELLS];
  logic signed [XW-1:0] y_s   [0:NCELLS];
  logic signed [ZW-1:0] z_s   [0:NCELLS];

  // advance the chain unless a finished result is held
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign x_coord  = s_tdata[COORD_WIDTH-1:0];
  assign y_coord  = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

  vhd_prerot #(
    .COORD_WIDTH(COORD_WIDTH),
    .XW(XW)
  ) u_prerot (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .valid_in(s_tvalid),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .ctl_out(ctl_s[0]),
    .x_out(x_s[0]),
    .y_out(y_s[0]),
    .z_out(z_s[0])
  );

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    vhd_cell #(
      .XW(XW),
      .IDX(i)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .en(adv),
      .ctl_in(ctl_s[i]),
      .x_in(x_s[i]),
      .y_in(y_s[i]),
      .z_in(z_s[i]),
      .ctl_out(ctl_s[i+1]),
      .x_out(x_s[i+1]),
      .y_out(y_s[i+1]),
      .z_out(z_s[i+1])
    );
  end

  vhd_post u_post (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .ctl_in(ctl_s[NCELLS]),
    .z_in(z_s[NCELLS]),
    .valid_out(m_tvalid),
    .heading(m_tdata)
  );

endmodule
`default_nettype wire

@@ src/vhd_checker.sv @@
// Port-level checks for the vector heading core, bound to the top level.
// Depends on vhd_pkg and vector_heading_degrees_core.
`default_nettype none
module vhd_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           s_tvalid,
  input wire                           s_tready,
  input wire                           m_tvalid,
  input wire                           m_tready,
  input wire [vhd_pkg::HEADING_W-1:0]  m_tdata
);
  import vhd_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata < HEADING_W'(FULL_TURN))
    else $error("heading outside [0, 360)");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output register");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // just after reset, an idle input leaves no result at the output
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !s_tvalid |=> !m_tvalid)
    else $error("result without transaction");

endmodule

bind vector_heading_degrees_core vhd_checker u_vhd_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for vector_heading_degrees_core: streams (x, y) vectors in and
// compares every heading against a CORDIC heading predictor kept in this file.
// Depends on vhd_pkg and the vector_heading_degrees_core RTL.
module tb_top;

  localparam int COORD_W     = 16;
  localparam int STEPS       = 16;
  localparam int LATENCY     = STEPS + 2;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int PRINT_CAP   = 40;

  localparam longint DEG_SCALE    = 64'sd65536;
  localparam longint QUARTER_Q16  = 64'sd90 * 64'sd65536;
  localparam longint TURN_Q7      = 64'sd46080;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_mode_t;

  typedef struct {
    logic signed [COORD_W-1:0]          x;
    logic signed [COORD_W-1:0]          y;
    logic [vhd_pkg::HEADING_W-1:0]      heading;
  } heading_expect_t;

  // atan(2^-i) in degrees * 2^16
  longint arctan_q16 [0:31] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [((2*COORD_W+7)/8)*8-1:0]     s_tdata = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [vhd_pkg::HEADING_W-1:0]      m_tdata;

  heading_expect_t pending_headings[$];
  int err_count      = 0;
  int vectors_sent   = 0;
  int headings_seen  = 0;
  int burst_left     = 0;
  int rx_hold_request = 0;

  vector_heading_degrees_core #(
    .COORD_WIDTH  (COORD_W),
    .CORDIC_STEPS (STEPS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Heading of (x, y): CORDIC vectoring in degrees * 2^16, offset, round, wrap.
  function automatic logic [vhd_pkg::HEADING_W-1:0] expected_heading(
    input logic signed [COORD_W-1:0] xc,
    input logic signed [COORD_W-1:0] yc
  );
    longint x, y, z, xs, ys, t, r;
    x = longint'(xc) * DEG_SCALE;
    y = longint'(yc) * DEG_SCALE;
    z = 0;
    if (x != 0 || y != 0) begin
      // fold the left half plane over by a quarter turn
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = QUARTER_Q16;
        end else begin
          x = -y;
          y = t;
          z = -QUARTER_Q16;
        end
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_q16[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_q16[i];
        end
      end
    end
    r = (z + QUARTER_Q16 + 256) >>> 9;
    r = r % TURN_Q7;
    if (r < 0) r = r + TURN_Q7;
    return r[vhd_pkg::HEADING_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP) $display("tb_top mismatch at %0t: %s", $realtime, msg);
  endtask

  // Offer one vector; returns at the falling edge after the transaction.
  task automatic send_vector(input logic signed [COORD_W-1:0] xv,
                             input logic signed [COORD_W-1:0] yv);
    heading_expect_t entry;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {yv, xv};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    entry.x = xv;
    entry.y = yv;
    entry.heading = expected_heading(xv, yv);
    pending_headings.push_back(entry);
    vectors_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Random vector, weighted toward the corners of the behavior.
  task automatic pick_vector(output logic signed [COORD_W-1:0] xv,
                             output logic signed [COORD_W-1:0] yv);
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      xv = COORD_W'($urandom_range(0, 65535));
      yv = COORD_W'($urandom_range(0, 65535));
    end else if (kind < 70) begin
      xv = COORD_W'($signed($urandom_range(0, 16)) - 8);
      yv = COORD_W'($signed($urandom_range(0, 16)) - 8);
    end else if (kind < 80) begin
      // on an axis, including the zero vector
      xv = ($urandom_range(0, 1) == 0) ? 16'sd0 : COORD_W'($urandom_range(0, 65535));
      yv = (xv == 0) ? COORD_W'($urandom_range(0, 65535)) : 16'sd0;
      if ($urandom_range(0, 7) == 0) yv = 16'sd0;
    end else if (kind < 90) begin
      // just either side of straight down, where the heading wraps
      xv = COORD_W'($signed($urandom_range(0, 6)) - 3);
      yv = -$signed({1'b0, 15'($urandom_range(1, 32767))});
      if ($urandom_range(0, 3) == 0) yv = 16'sh8000;
    end else begin
      xv = COORD_W'($urandom_range(0, 65535));
      yv = ($urandom_range(0, 1) == 0) ? xv : -xv;
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_headings.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_cases();
    logic signed [COORD_W-1:0] xs [0:23];
    logic signed [COORD_W-1:0] ys [0:23];
    xs = '{ 0,  0,  0,  1, -1, 32767, -32768, -32768,  32767, -32768,      0,
            32767,     0, -1, -1,  1,  1, -1,      1, -32768, -32768, 5, -5, -32768};
    ys = '{ 0, -1,  1,  0,  0, 32767, -32768,  32767, -32768,      0, -32768,
            0, 32767, -1,  1, -1,  1, -32768, -32768, -1,      1, -5,  5, 32767};
    for (int i = 0; i < 24; i++) send_vector(xs[i], ys[i]);
    wait_drained();
  endtask

  task automatic test_random_vectors(input int count);
    logic signed [COORD_W-1:0] xv, yv;
    for (int i = 0; i < count; i++) begin
      pick_vector(xv, yv);
      send_vector(xv, yv);
    end
  endtask

  // Receiver holds off while vectors keep coming, so the pipeline fills and stalls.
  task automatic test_output_backpressure();
    logic signed [COORD_W-1:0] xv, yv;
    rx_hold_request = LONG_HOLD;
    for (int i = 0; i < 100; i++) begin
      pick_vector(xv, yv);
      send_vector(xv, yv);
    end
    wait_drained();
  endtask

  task automatic test_pause_and_resume();
    wait_drained();
    repeat (LATENCY) @(negedge clk);
    test_random_vectors(80);
  endtask

  // Receiver: modes of random length, plus the long hold-off on request.
  initial begin : rx_pattern
    rx_mode_t mode;
    int mode_left;
    int hold_left;
    int phase;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_request > 0) begin
        hold_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 120);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN:      m_tready <= 1'b1;
          RX_LIGHT:     m_tready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY:     m_tready <= ($urandom_range(0, 3) == 0);
          RX_ALTERNATE: m_tready <= (phase % 3 != 0);
          default:      m_tready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : heading_checker
    heading_expect_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        headings_seen++;
        if (pending_headings.size() == 0) begin
          report_mismatch($sformatf("unexpected heading %0d", m_tdata));
        end else begin
          want = pending_headings.pop_front();
          if (m_tdata !== want.heading)
            report_mismatch($sformatf("x=%0d y=%0d heading %0d, want %0d",
                                      want.x, want.y, m_tdata, want.heading));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_top: watchdog expired after %0d quiet cycles", STALL_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  initial begin : main_sequence
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_cases();
    test_random_vectors(650);
    test_output_backpressure();
    test_pause_and_resume();
    wait_drained();
    repeat (LATENCY + 4) @(negedge clk);
    if (pending_headings.size() != 0)
      report_mismatch($sformatf("%0d headings never arrived", pending_headings.size()));
    $display("tb_top: %0d vectors sent, %0d headings checked; axes, extremes, wrap, stalls",
             vectors_sent, headings_seen);
    $display("tb_top: %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
